>>> sv/iht_pkg.sv
// ----------------------------------------------------------------------------
// iht_pkg
// Shared types and constants for the image barrier hazard tracker: command
// codes, write-access bits, table geometry and the transfer payloads.
// ----------------------------------------------------------------------------
package iht_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Command codes
   localparam logic [1:0] CMD_ACCESS  = 2'd0;
   localparam logic [1:0] CMD_SET     = 2'd1;
   localparam logic [1:0] CMD_DISCARD = 2'd2;

   // Layout code for an untracked image
   localparam logic [31:0] LAYOUT_UNDEFINED = 32'd0;

   // Access bits that count as writes after reset
   localparam logic [63:0] ACC_SHADER_STORAGE_WRITE = 64'h0000_0000_0000_0040;
   localparam logic [63:0] ACC_COLOR_ATT_WRITE      = 64'h0000_0000_0000_0100;
   localparam logic [63:0] ACC_DEPTH_STENCIL_WRITE  = 64'h0000_0000_0000_0400;
   localparam logic [63:0] ACC_TRANSFER_WRITE       = 64'h0000_0000_0000_1000;
   localparam logic [63:0] ACC_HOST_WRITE           = 64'h0000_0000_0000_4000;
   localparam logic [63:0] ACC_MEMORY_WRITE         = 64'h0000_0000_0001_0000;
   localparam logic [63:0] WRITE_MASK_RESET = ACC_SHADER_STORAGE_WRITE
                                            | ACC_COLOR_ATT_WRITE
                                            | ACC_DEPTH_STENCIL_WRITE
                                            | ACC_TRANSFER_WRITE
                                            | ACC_HOST_WRITE
                                            | ACC_MEMORY_WRITE;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] image_id;
      logic [31:0] layout;
      logic [63:0] stage_mask;
      logic [63:0] access_mask;
      logic [7:0]  aspect;
      logic [10:0] base_layer;
      logic [31:0] layer_count;
   } req_type;

   typedef struct packed {
      logic        barrier_valid;
      logic [63:0] barrier_image;
      logic [31:0] old_layout;
      logic [31:0] new_layout;
      logic [63:0] src_stage;
      logic [63:0] src_access;
      logic [63:0] dst_stage;
      logic [63:0] dst_access;
      logic [7:0]  out_aspect;
      logic [10:0] out_base_layer;
      logic [31:0] out_layer_count;
      logic        table_full;
   } rsp_type;

   // One tracked image as held in the table memory
   typedef struct packed {
      logic [63:0] image;
      logic [31:0] layout;
      logic [63:0] stage;
      logic [63:0] access;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> sv/iht_ram.sv
// ----------------------------------------------------------------------------
// iht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module iht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/image_barrier_hazard_tracker_top.sv
// ----------------------------------------------------------------------------
// image_barrier_hazard_tracker_top
// Tracks layout, stage and access state per image in a small table memory and
// issues a barrier description whenever a declared access hazards or changes
// layout.
//
//   Channel | Ports                          | Direction | Moves
//   --------+--------------------------------+-----------+-------------------
//   req     | req_valid req_stall req_payload| in        | one command
//   rsp     | rsp_valid rsp_stall rsp_payload| out       | one result/command
//   csr     | csr_we csr_wdata               | in        | write mask
//
// The table memory has one read port and is swept once per command: one read
// a cycle over all TABLE_ENTRIES entries, each entry checked in the cycle after
// its read. The result is registered once the sweep ends, and a new command is
// taken only after the last one has finished its sweep and completed.
// Reset clears the entry valid flags at once; no clearing pass follows.
// A finished result waits in the output register while the next command is
// taken; the command only completes once that register is free.
// ----------------------------------------------------------------------------
module image_barrier_hazard_tracker_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iht_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iht_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [63:0]      csr_wdata
);
   import iht_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]               state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [CNT_W-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                     chk_ff, chk_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   entry_type                cur_ff, cur_in;
   logic                     free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0]              wmask_ff, wmask_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   entry_type        ram_rdata;
   logic [ENTRY_W-1:0] ram_rbits;

   logic [31:0]      cur_lay;
   logic [63:0]      cur_st;
   logic [63:0]      cur_ac;
   logic             hazard;
   logic             have_slot;
   logic [IDX_W-1:0] tgt_slot;
   logic             rsp_free;
   rsp_type          res;

   iht_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(scan_cnt_ff[IDX_W-1:0]),
      .rdata(ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   // Tracked state as seen by the command; untracked reads as undefined
   always_comb begin
      cur_lay   = found_ff ? cur_ff.layout : LAYOUT_UNDEFINED;
      cur_st    = found_ff ? cur_ff.stage  : 64'd0;
      cur_ac    = found_ff ? cur_ff.access : 64'd0;
      hazard    = ((req_ff.access_mask & wmask_ff) != 64'd0)
               || ((cur_ac & wmask_ff) != 64'd0);
      have_slot = found_ff || free_ok_ff;
      tgt_slot  = found_ff ? slot_ff : free_idx_ff;
      rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Build the result and the write-back for the finishing command
   always_comb begin
      res       = '0;
      ram_we    = 1'b0;
      ram_waddr = tgt_slot;
      ram_wdata = '{image: req_ff.image_id, layout: req_ff.layout,
                    stage: req_ff.stage_mask, access: req_ff.access_mask};
      case (req_ff.cmd)
         CMD_ACCESS: begin
            res.table_full = !have_slot;
            ram_we         = have_slot;
            if (cur_lay == req_ff.layout && !hazard) begin
               ram_wdata.layout = cur_lay;
               ram_wdata.stage  = cur_st | req_ff.stage_mask;
               ram_wdata.access = cur_ac | req_ff.access_mask;
            end else begin
               res.barrier_valid   = 1'b1;
               res.barrier_image   = req_ff.image_id;
               res.old_layout      = cur_lay;
               res.new_layout      = req_ff.layout;
               res.src_stage       = (cur_lay == LAYOUT_UNDEFINED) ? 64'd0 : cur_st;
               res.src_access      = (cur_lay == LAYOUT_UNDEFINED) ? 64'd0 : cur_ac;
               res.dst_stage       = req_ff.stage_mask;
               res.dst_access      = req_ff.access_mask;
               res.out_aspect      = req_ff.aspect;
               res.out_base_layer  = req_ff.base_layer;
               res.out_layer_count = req_ff.layer_count;
            end
         end
         CMD_SET: begin
            res.table_full = !have_slot;
            ram_we         = have_slot;
         end
         default: begin
         end
      endcase
      // Hold the write until the result can be taken
      ram_we = ram_we && state_ff == ST_DONE && rsp_free;
   end

   // Sequencer: take a command, sweep the table, then complete
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_cnt_in  = scan_cnt_ff;
      chk_in       = 1'b0;
      chk_idx_in   = scan_cnt_ff[IDX_W-1:0];
      found_in     = found_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      wmask_in     = csr_we ? csr_wdata : wmask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_payload;
               scan_cnt_in = '0;
               found_in    = 1'b0;
               free_ok_in  = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle
            if (scan_cnt_ff < CNT_W'(TABLE_ENTRIES)) begin
               chk_in      = 1'b1;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
            // Check the entry read last cycle
            if (chk_ff) begin
               if (valid_ff[chk_idx_ff] && ram_rdata.image == req_ff.image_id
                   && !found_ff) begin
                  found_in = 1'b1;
                  slot_in  = chk_idx_ff;
                  cur_in   = ram_rdata;
               end
               if (!valid_ff[chk_idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (chk_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in       = res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (ram_we) begin
                  valid_in[tgt_slot] = 1'b1;
               end
               if (req_ff.cmd == CMD_DISCARD && found_ff) begin
                  valid_in[slot_ff] = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         wmask_ff     <= WRITE_MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         valid_ff     <= valid_in;
         wmask_ff     <= wmask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_cnt_ff <= scan_cnt_in;
      chk_idx_ff  <= chk_idx_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      cur_ff      <= cur_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> sv/iht_checker.sv
// ----------------------------------------------------------------------------
// iht_checker
// Port-level checks for the image barrier hazard tracker, bound to the top.
// ----------------------------------------------------------------------------
module iht_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input iht_pkg::rsp_type rsp_payload
);
   import iht_pkg::*;

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // One command at a time: a transfer closes the input
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken during a sweep");

   // No barrier means empty barrier fields
   a_no_barrier_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.barrier_valid |->
         rsp_payload.barrier_image == 64'd0 && rsp_payload.new_layout == 32'd0
         && rsp_payload.dst_access == 64'd0 && rsp_payload.out_layer_count == 32'd0)
      else $error("barrier fields set without a barrier");

   // Undefined old layout carries no source scope
   a_undef_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.old_layout == LAYOUT_UNDEFINED |->
         rsp_payload.src_stage == 64'd0 && rsp_payload.src_access == 64'd0)
      else $error("source scope from an undefined layout");

endmodule

bind image_barrier_hazard_tracker_top iht_checker u_iht_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image barrier hazard tracker testbench
// Drives declare, set and discard commands into the tracker and checks every
// result against a behavioural copy of the image table kept in this bench. A
// short list of hand-picked commands runs first. Random phases follow, each
// under a different write-access mask, most with bursts of idling on one or both sides.
// ----------------------------------------------------------------------------
module testbench;
   import iht_pkg::*;

   localparam int          CLK_PERIOD      = 10;
   localparam int          RESET_CYCLES    = 7;
   localparam int          DRAIN_CYCLES    = TABLE_ENTRIES + 8;
   localparam int          HOLD_OFF_CYCLES = 200;
   localparam int          PHASE_ITEMS     = 250;
   localparam int          NUM_PHASES      = 5;
   localparam int          ID_POOL         = 20;
   localparam int          MAX_REPORTS     = 10;
   localparam longint      TIMEOUT_NS      = 64'd5_000_000;
   localparam logic [1:0]  CMD_UNUSED      = 2'd3;
   localparam logic [63:0] ACC_SHADER_READ = 64'h0000_0000_0000_0020;
   localparam logic [63:0] ACC_COLOR_READ  = 64'h0000_0000_0000_0080;
   localparam logic [63:0] ALL_ONES        = {64{1'b1}};

   // One row of the hand-written stimulus; reps sends it again with the id advanced
   typedef struct {
      req_type     req;
      int unsigned reps;
      bit          fixed;
      rsp_type     want;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_we;
   logic [63:0] csr_wdata;

   // Bench copy of the image table and the write mask
   logic        trk_valid  [TABLE_ENTRIES];
   logic [63:0] trk_image  [TABLE_ENTRIES];
   logic [31:0] trk_layout [TABLE_ENTRIES];
   logic [63:0] trk_stage  [TABLE_ENTRIES];
   logic [63:0] trk_access [TABLE_ENTRIES];
   logic [63:0] wr_mask;

   rsp_type      due_results [$];
   step_row_type directed_steps [$];
   logic [63:0]  id_pool [ID_POOL];
   int unsigned  mismatch_count = 0;
   int unsigned  result_count   = 0;
   bit           tx_idle_en     = 1'b0;
   bit           rx_idle_en     = 1'b0;
   bit           hold_off_req   = 1'b0;

   image_barrier_hazard_tracker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one command to the bench table and return the result it should give
   function automatic rsp_type track_command(input req_type r);
      rsp_type     res;
      int          hit;
      int          slot;
      logic [31:0] cur_lay;
      logic [63:0] cur_st;
      logic [63:0] cur_ac;
      bit          hazard;
      res     = '0;
      hit     = -1;
      slot    = -1;
      cur_lay = LAYOUT_UNDEFINED;
      cur_st  = '0;
      cur_ac  = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && trk_valid[i] && trk_image[i] == r.image_id) hit = i;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (slot < 0 && !trk_valid[i]) slot = i;
      end
      case (r.cmd)
         CMD_ACCESS: begin
            if (hit >= 0) begin
               slot    = hit;
               cur_lay = trk_layout[hit];
               cur_st  = trk_stage[hit];
               cur_ac  = trk_access[hit];
            end else if (slot < 0) begin
               res.table_full = 1'b1;
            end
            hazard = ((r.access_mask | cur_ac) & wr_mask) != '0;
            if (cur_lay == r.layout && !hazard) begin
               // same layout, reads only: widen the tracked scope
               if (slot >= 0) begin
                  trk_valid[slot]  = 1'b1;
                  trk_image[slot]  = r.image_id;
                  trk_layout[slot] = cur_lay;
                  trk_stage[slot]  = cur_st | r.stage_mask;
                  trk_access[slot] = cur_ac | r.access_mask;
               end
            end else begin
               res.barrier_valid   = 1'b1;
               res.barrier_image   = r.image_id;
               res.old_layout      = cur_lay;
               res.new_layout      = r.layout;
               res.src_stage       = (cur_lay == LAYOUT_UNDEFINED) ? '0 : cur_st;
               res.src_access      = (cur_lay == LAYOUT_UNDEFINED) ? '0 : cur_ac;
               res.dst_stage       = r.stage_mask;
               res.dst_access      = r.access_mask;
               res.out_aspect      = r.aspect;
               res.out_base_layer  = r.base_layer;
               res.out_layer_count = r.layer_count;
               if (slot >= 0) begin
                  trk_valid[slot]  = 1'b1;
                  trk_image[slot]  = r.image_id;
                  trk_layout[slot] = r.layout;
                  trk_stage[slot]  = r.stage_mask;
                  trk_access[slot] = r.access_mask;
               end
            end
         end
         CMD_SET: begin
            if (hit >= 0) slot = hit;
            if (slot < 0) begin
               res.table_full = 1'b1;
            end else begin
               trk_valid[slot]  = 1'b1;
               trk_image[slot]  = r.image_id;
               trk_layout[slot] = r.layout;
               trk_stage[slot]  = r.stage_mask;
               trk_access[slot] = r.access_mask;
            end
         end
         CMD_DISCARD: begin
            if (hit >= 0) trk_valid[hit] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Add one row to the directed table
   function automatic void append_step(input logic [1:0] cmd, input logic [63:0] id,
                                       input logic [31:0] lay, input logic [63:0] st,
                                       input logic [63:0] ac, input logic [7:0] asp,
                                       input logic [10:0] base, input logic [31:0] cnt,
                                       input int unsigned reps, input bit fixed,
                                       input rsp_type want);
      step_row_type row;
      row.req  = '{cmd: cmd, image_id: id, layout: lay, stage_mask: st, access_mask: ac,
                   aspect: asp, base_layer: base, layer_count: cnt};
      row.reps  = reps;
      row.fixed = fixed;
      row.want  = want;
      directed_steps.insert(directed_steps.size(), row);
   endfunction

   // Offer one command, hold it until the transfer, then log what it should return
   task automatic transfer_command(input req_type r, input bit fixed, input rsp_type want);
      rsp_type predicted;
      if (tx_idle_en && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 7)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = track_command(r);
      due_results.insert(due_results.size(), fixed ? want : predicted);
   endtask

   // Stop offering and wait until every outstanding result has come back
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      wr_mask = value;
   endtask

   // Random commands over a small pool of ids so that entries are reused and the table fills
   task automatic run_random_phase(input int phase);
      req_type     r;
      int unsigned pick;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (phase == 1 && n == 60) hold_off_req = 1'b1;
         if (phase == 2 && n == PHASE_ITEMS / 2) settle_idle();
         pick = $urandom_range(0, 99);
         r.cmd = (pick < 70) ? CMD_ACCESS : (pick < 85) ? CMD_SET :
                 (pick < 97) ? CMD_DISCARD : CMD_UNUSED;
         r.image_id = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                                   : id_pool[$urandom_range(0, ID_POOL - 1)];
         r.layout = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 2));
         r.stage_mask = ($urandom_range(0, 7) == 0) ? 64'd0 : {$urandom, $urandom};
         pick = $urandom_range(0, 9);
         r.access_mask = (pick < 5) ? ({$urandom, $urandom} & ~wr_mask) :
                         (pick < 7) ? 64'd0 : {$urandom, $urandom};
         r.aspect      = 8'($urandom);
         r.base_layer  = 11'($urandom);
         r.layer_count = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom;
         transfer_command(r, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("result %0d: %s expected %h, got %h", result_count, name, want, got);
      end
   endtask

   // Compare each result transfer with the oldest outstanding expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result %0d: nothing expected, got %h", result_count, rsp_payload);
         end else begin
            want = due_results.pop_front();
            check_field("barrier_valid", 64'(want.barrier_valid),
                        64'(rsp_payload.barrier_valid));
            check_field("barrier_image", want.barrier_image, rsp_payload.barrier_image);
            check_field("old_layout", 64'(want.old_layout), 64'(rsp_payload.old_layout));
            check_field("new_layout", 64'(want.new_layout), 64'(rsp_payload.new_layout));
            check_field("src_stage", want.src_stage, rsp_payload.src_stage);
            check_field("src_access", want.src_access, rsp_payload.src_access);
            check_field("dst_stage", want.dst_stage, rsp_payload.dst_stage);
            check_field("dst_access", want.dst_access, rsp_payload.dst_access);
            check_field("out_aspect", 64'(want.out_aspect), 64'(rsp_payload.out_aspect));
            check_field("out_base_layer", 64'(want.out_base_layer),
                        64'(rsp_payload.out_base_layer));
            check_field("out_layer_count", 64'(want.out_layer_count),
                        64'(rsp_payload.out_layer_count));
            check_field("table_full", 64'(want.table_full), 64'(rsp_payload.table_full));
         end
         result_count++;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", due_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      req_type     cmd_item;
      rsp_type     only_full;
      rsp_type     want_first_use;
      rsp_type     want_max_write;
      logic [63:0] phase_mask;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      wr_mask = WRITE_MASK_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) trk_valid[i] = 1'b0;
      id_pool[0] = 64'd0;
      id_pool[1] = ALL_ONES;
      for (int i = 2; i < ID_POOL; i++) id_pool[i] = {$urandom, $urandom};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      only_full = '0;
      only_full.table_full = 1'b1;
      want_first_use = '{barrier_valid: 1'b1, barrier_image: 64'd0, old_layout: 32'd0,
                         new_layout: 32'd1, src_stage: 64'd0, src_access: 64'd0,
                         dst_stage: ALL_ONES, dst_access: ACC_SHADER_READ,
                         out_aspect: 8'hFF, out_base_layer: 11'h7FF,
                         out_layer_count: 32'hFFFF_FFFF, table_full: 1'b0};
      want_max_write = '{barrier_valid: 1'b1, barrier_image: ALL_ONES, old_layout: 32'd0,
                         new_layout: 32'hFFFF_FFFF, src_stage: 64'd0, src_access: 64'd0,
                         dst_stage: ALL_ONES, dst_access: ALL_ONES, out_aspect: 8'd0,
                         out_base_layer: 11'd0, out_layer_count: 32'd0, table_full: 1'b0};

      // Hand-picked commands under the mask left by reset
      // unknown id, undefined layout, no access: tracked silently
      append_step(CMD_ACCESS, 64'd0, 32'd0, 64'd0, 64'd0,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, '0);
      // first real use of the image: barrier with empty source scope
      append_step(CMD_ACCESS, 64'd0, 32'd1, ALL_ONES,
                  ACC_SHADER_READ, 8'hFF, 11'h7FF, 32'hFFFF_FFFF,
                  1, 1'b1, want_first_use);
      // same layout, reads only: masks merge, no barrier
      append_step(CMD_ACCESS, 64'd0, 32'd1, 64'd1,
                  ACC_COLOR_READ, 8'd1, 11'd1, 32'd1, 1, 1'b1, '0);
      // layout change carries the merged masks as source
      append_step(CMD_ACCESS, 64'd0, 32'd2, 64'd2, 64'd0,
                  8'd3, 11'd5, 32'd2, 1, 1'b0, '0);
      append_step(CMD_ACCESS, ALL_ONES, 32'hFFFF_FFFF, ALL_ONES,
                  ALL_ONES, 8'd0, 11'd0, 32'd0, 1, 1'b1,
                  want_max_write);
      // read after a tracked write: hazard at an unchanged layout
      append_step(CMD_ACCESS, ALL_ONES, 32'hFFFF_FFFF, 64'd4,
                  ACC_SHADER_READ, 8'd1, 11'd1, 32'd1, 1, 1'b0, '0);
      append_step(CMD_SET, 64'd5, 32'd3, 64'd8, ACC_TRANSFER_WRITE,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, '0);
      append_step(CMD_ACCESS, 64'd5, 32'd3, 64'd16, ACC_SHADER_READ,
                  8'd2, 11'd10, 32'd6, 1, 1'b0, '0);
      append_step(CMD_DISCARD, 64'd5, 32'd0, 64'd0, 64'd0,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, '0);
      // discarded image is back to undefined
      append_step(CMD_ACCESS, 64'd5, 32'd3, 64'd16, ACC_SHADER_READ,
                  8'd2, 11'd10, 32'd6, 1, 1'b0, '0);
      // discard of an id never seen
      append_step(CMD_DISCARD, 64'hDEAD_BEEF, 32'd0, 64'd0, 64'd0,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, '0);
      // unused command code is ignored
      append_step(CMD_UNUSED, 64'd0, 32'hFFFF_FFFF, ALL_ONES,
                  ALL_ONES, 8'hFF, 11'h7FF, 32'hFFFF_FFFF,
                  1, 1'b1, '0);
      // write into an undefined layout that stays undefined
      append_step(CMD_ACCESS, 64'd7, 32'd0, 64'd1,
                  ACC_COLOR_ATT_WRITE, 8'd1, 11'd0, 32'd1,
                  1, 1'b0, '0);
      // fill the rest of the table
      append_step(CMD_SET, 64'h100, 32'd4, 64'd1, ACC_SHADER_READ,
                  8'd0, 11'd0, 32'd0, 12, 1'b1, '0);
      // full table: decision against undefined state, nothing stored
      append_step(CMD_ACCESS, 64'h200, 32'd5, 64'd2, ACC_SHADER_READ,
                  8'd4, 11'd3, 32'd1, 1, 1'b0, '0);
      append_step(CMD_ACCESS, 64'h201, 32'd0, 64'd2, ACC_SHADER_READ,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, only_full);
      append_step(CMD_SET, 64'h202, 32'd6, 64'd1, 64'd0,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, only_full);
      // known id still updates while the table is full
      append_step(CMD_SET, 64'h100, 32'd6, 64'd1, 64'd0,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, '0);
      append_step(CMD_DISCARD, 64'h100, 32'd0, 64'd0, 64'd0,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, '0);
      append_step(CMD_SET, 64'h202, 32'd7, 64'd4, 64'd0,
                  8'd0, 11'd0, 32'd0, 1, 1'b1, '0);
      append_step(CMD_ACCESS, 64'h202, 32'd7, 64'd8, ACC_SHADER_READ,
                  8'd5, 11'd9, 32'd3, 1, 1'b0, '0);

      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      for (int k = 0; k < directed_steps.size(); k++) begin
         for (int unsigned n = 0; n < directed_steps[k].reps; n++) begin
            cmd_item = directed_steps[k].req;
            cmd_item.image_id = cmd_item.image_id + 64'(n);
            transfer_command(cmd_item, directed_steps[k].fixed, directed_steps[k].want);
         end
      end
      settle_idle();

      // Random phases, each under its own write mask; the last one runs without idling
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       phase_mask = ALL_ONES;
            1:       phase_mask = 64'd0;
            2:       phase_mask = {$urandom, $urandom};
            3:       phase_mask = 64'd1 << $urandom_range(0, 63);
            default: phase_mask = WRITE_MASK_RESET;
         endcase
         write_mask(phase_mask);
         tx_idle_en = (p == 0 || p == 2 || p == 3);
         rx_idle_en = (p == 0 || p == 1 || p == 3);
         run_random_phase(p);
         settle_idle();
      end

      if (mismatch_count == 0 && due_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
